FILE: sv/ipv6_five_tuple_flow_classifier_top_macros.svh
// Assertion macros for the flow classifier
`ifndef IPV6_FIVE_TUPLE_FLOW_CLASSIFIER_TOP_MACROS_SVH
`define IPV6_FIVE_TUPLE_FLOW_CLASSIFIER_TOP_MACROS_SVH
// implication checked every clock, quiet during reset
`define AST_IMPL(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("assertion failed");
// next-cycle implication
`define AST_NEXT(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("assertion failed");
`endif

FILE: sv/ipv6fc_pkg.sv
// ---------------------------------------------------------------------------
// ipv6fc_pkg
// Shared types and constants of the IPv6 flow classifier.
// ---------------------------------------------------------------------------
package ipv6fc_pkg;
    localparam int MAX_FLOWS     = 256;
    localparam int COUNTER_WIDTH = 32;
    localparam int DSCP_CODES    = 64;
    localparam logic [7:0]  PROTO_TCP   = 8'd6;
    localparam logic [7:0]  PROTO_UDP   = 8'd17;
    localparam logic [15:0] MIN_PAYLOAD = 16'd4;
    localparam logic [7:0]  MCAST_BYTE  = 8'hff;
    localparam int KEY_W = 64 * 4 + 40;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_MCAST = 3'd1,
        ST_PROTO = 3'd2,
        ST_SHORT = 3'd3,
        ST_FULL  = 3'd4
    } t_status;

    // classified item handed from front to back
    typedef struct packed {
        t_status    status;
        logic [KEY_W-1:0] key;
        logic [5:0] dscp;
    } t_job;
endpackage

FILE: sv/ipv6_five_tuple_flow_classifier_top.sv
// ---------------------------------------------------------------------------
// ipv6_five_tuple_flow_classifier_top
// IPv6 five-tuple flow classifier with per-flow and per-DSCP counters.
// ---------------------------------------------------------------------------
// Usage:
//  s_axis carries one header summary per beat; m_axis returns one result.
//  A rejected packet (multicast, non TCP/UDP, short payload) is answered
//  without a table search. A classified packet walks the flow table one
//  entry at a time through the key RAM read port, then updates the flow
//  and DSCP counter RAMs by read-modify-write; a miss on a full table
//  answers table-full. A two-beat queue lets the front take headers while
//  the back works. After reset a clearing pass zeroes the MAX_FLOWS*64
//  DSCP counter entries (16384 by default); headers queue up but none is
//  processed. When m_axis_tready is low the result holds and the back waits.
// ---------------------------------------------------------------------------
module ipv6_five_tuple_flow_classifier_top #(
    parameter int MAX_FLOWS     = ipv6fc_pkg::MAX_FLOWS,
    parameter int COUNTER_WIDTH = ipv6fc_pkg::COUNTER_WIDTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // src_addr_hi, src_addr_lo, dst_addr_hi, dst_addr_lo, next_header,
    // payload_length, source_port, destination_port, dscp, zero fill
    input  logic [319:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status, flow_number, packet_index, dscp_packet_count, zero fill
    output logic [79:0]  m_axis_tdata
);
    logic w_qv, w_qr;
    ipv6fc_pkg::t_job w_job;
    logic [2:0]  w_st;
    logic [8:0]  w_fl;
    logic [31:0] w_pi, w_dc;

    ipv6fc_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_sh(s_axis_tdata[63:0]), .i_sl(s_axis_tdata[127:64]),
        .i_dh(s_axis_tdata[191:128]), .i_dl(s_axis_tdata[255:192]),
        .i_nh(s_axis_tdata[263:256]), .i_plen(s_axis_tdata[279:264]),
        .i_sp(s_axis_tdata[295:280]), .i_dp(s_axis_tdata[311:296]),
        .i_dscp(s_axis_tdata[317:312]),
        .o_valid(w_qv), .i_ready(w_qr), .o_job(w_job));

    ipv6fc_back #(.MAX_FLOWS(MAX_FLOWS), .COUNTER_WIDTH(COUNTER_WIDTH)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_qv), .o_ready(w_qr), .i_job(w_job),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_status(w_st), .o_flow(w_fl), .o_pidx(w_pi), .o_dcnt(w_dc));

    assign m_axis_tdata = {4'd0, w_dc, w_pi, w_fl, w_st};
endmodule

FILE: sv/ipv6fc_ram.sv
// ---------------------------------------------------------------------------
// ipv6fc_ram
// Generic single-port-write, single-read RAM with registered read.
// ---------------------------------------------------------------------------
module ipv6fc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

FILE: sv/ipv6fc_front.sv
// ---------------------------------------------------------------------------
// ipv6fc_front
// Screens headers and packs the five-tuple key; a two-entry queue feeds back.
// ---------------------------------------------------------------------------
module ipv6fc_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [63:0]        i_sh,
    input  logic [63:0]        i_sl,
    input  logic [63:0]        i_dh,
    input  logic [63:0]        i_dl,
    input  logic [7:0]         i_nh,
    input  logic [15:0]        i_plen,
    input  logic [15:0]        i_sp,
    input  logic [15:0]        i_dp,
    input  logic [5:0]         i_dscp,
    output logic               o_valid,
    input  logic               i_ready,
    output ipv6fc_pkg::t_job   o_job
);
    ipv6fc_pkg::t_job r_q [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    ipv6fc_pkg::t_job w_job;

    // screening in the model's check order
    always_comb begin
        w_job.key  = {i_sh, i_sl, i_dh, i_dl, i_nh, i_sp, i_dp};
        w_job.dscp = i_dscp;
        if (i_dh[63:56] == ipv6fc_pkg::MCAST_BYTE) begin
            w_job.status = ipv6fc_pkg::ST_MCAST;
        end else if (i_nh != ipv6fc_pkg::PROTO_TCP && i_nh != ipv6fc_pkg::PROTO_UDP) begin
            w_job.status = ipv6fc_pkg::ST_PROTO;
        end else if (i_plen < ipv6fc_pkg::MIN_PAYLOAD) begin
            w_job.status = ipv6fc_pkg::ST_SHORT;
        end else begin
            w_job.status = ipv6fc_pkg::ST_OK;
        end
    end

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_q[r_rp];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_q[r_wp] <= w_job;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_valid && o_ready) r_wp <= ~r_wp;
            if (o_valid && i_ready) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_valid && o_ready) - 2'(o_valid && i_ready);
        end
    end
endmodule

FILE: sv/ipv6fc_back.sv
// ---------------------------------------------------------------------------
// ipv6fc_back
// Flow table search, allocation and saturating counter updates.
// ---------------------------------------------------------------------------
`include "ipv6_five_tuple_flow_classifier_top_macros.svh"
module ipv6fc_back #(
    parameter int MAX_FLOWS     = ipv6fc_pkg::MAX_FLOWS,
    parameter int COUNTER_WIDTH = ipv6fc_pkg::COUNTER_WIDTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  ipv6fc_pkg::t_job i_job,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [2:0]       o_status,
    output logic [8:0]       o_flow,
    output logic [31:0]      o_pidx,
    output logic [31:0]      o_dcnt
);
    localparam int AW  = $clog2(MAX_FLOWS);
    localparam int DAW = AW + 6;
    localparam int CW  = COUNTER_WIDTH;
    localparam int NW  = AW + 1;
    localparam int KW  = ipv6fc_pkg::KEY_W;
    localparam int DDEPTH = MAX_FLOWS * ipv6fc_pkg::DSCP_CODES;
    localparam logic [CW-1:0] CMAX = '1;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SRCH  = 7'b0000010,
        S_CMP   = 7'b0000100,
        S_RD    = 7'b0001000,
        S_WAIT  = 7'b0010000,
        S_WR    = 7'b0100000,
        S_CLR   = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    ipv6fc_pkg::t_job r_job;
    logic [NW-1:0] r_idx, r_next, r_hit;
    logic r_found;
    logic [DAW-1:0] r_clr;
    logic r_ovalid;
    logic [2:0] r_st;
    logic [8:0] r_fl;
    logic [31:0] r_pi, r_dc;
    logic [CW-1:0] r_fcnt;

    // memories
    logic           w_kwe, w_fwe, w_dwe;
    logic [AW-1:0]  w_kra, w_fra, w_fwa;
    logic [KW-1:0]  w_krd;
    logic [CW-1:0]  w_frd, w_fwd, w_drd, w_dwd;
    logic [DAW-1:0] w_da, w_dwa;

    ipv6fc_ram #(.WIDTH(KW), .DEPTH(MAX_FLOWS)) u_key (
        .i_clk(i_clk), .i_we(w_kwe), .i_waddr(r_next[AW-1:0]), .i_wdata(r_job.key),
        .i_raddr(w_kra), .o_rdata(w_krd));
    ipv6fc_ram #(.WIDTH(CW), .DEPTH(MAX_FLOWS)) u_fcnt (
        .i_clk(i_clk), .i_we(w_fwe), .i_waddr(w_fwa), .i_wdata(w_fwd),
        .i_raddr(w_fra), .o_rdata(w_frd));
    ipv6fc_ram #(.WIDTH(CW), .DEPTH(DDEPTH)) u_dcnt (
        .i_clk(i_clk), .i_we(w_dwe), .i_waddr(w_dwa), .i_wdata(w_dwd),
        .i_raddr(w_da), .o_rdata(w_drd));

    assign w_kra = r_idx[AW-1:0];
    assign w_fra = r_hit[AW-1:0];
    assign w_fwa = r_hit[AW-1:0];
    assign w_da  = {r_hit[AW-1:0], r_job.dscp};
    assign w_kwe = (r_state == S_WR) && !r_found;
    assign w_fwe = (r_state == S_WR);
    assign w_fwd = r_found ? ((r_fcnt == CMAX) ? r_fcnt : r_fcnt + 1'b1) : '0;
    assign w_dwe = (r_state == S_WR) || (r_state == S_CLR);
    assign w_dwa = (r_state == S_CLR) ? r_clr : w_da;
    assign w_dwd = (r_state == S_CLR) ? '0 : ((w_drd == CMAX) ? w_drd : w_drd + 1'b1);

    assign o_ready  = (r_state == S_IDLE) && !r_ovalid;
    assign o_valid  = r_ovalid;
    assign o_status = r_st;
    assign o_flow   = r_fl;
    assign o_pidx   = r_pi;
    assign o_dcnt   = r_dc;

    // next state; entries below r_next are all in use
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLR:  if (r_clr == DAW'(DDEPTH - 1)) n_state = S_IDLE;
            S_IDLE: if (i_valid && o_ready)
                        n_state = (i_job.status == ipv6fc_pkg::ST_OK) ? S_SRCH : S_IDLE;
            S_SRCH: n_state = (r_idx >= r_next) ? S_RD : S_CMP;
            S_CMP:  n_state = (w_krd == r_job.key) ? S_RD : S_SRCH;
            S_RD:   n_state = (!r_found && r_next >= NW'(MAX_FLOWS)) ? S_IDLE : S_WAIT;
            S_WAIT: n_state = S_WR;
            S_WR:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer; one key compared per S_SRCH, S_CMP pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_next   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            case (r_state)
                S_CLR: r_clr <= r_clr + 1'b1;
                S_IDLE: if (i_valid && o_ready) begin
                    r_job   <= i_job;
                    r_idx   <= '0;
                    r_found <= 1'b0;
                    if (i_job.status != ipv6fc_pkg::ST_OK) begin
                        r_ovalid <= 1'b1;
                        r_st <= i_job.status;
                        r_fl <= '0; r_pi <= '0; r_dc <= '0;
                    end
                end
                S_SRCH: if (r_idx >= r_next) r_hit <= r_next;
                S_CMP: begin
                    if (w_krd == r_job.key) begin
                        r_found <= 1'b1;
                        r_hit   <= r_idx;
                    end
                    r_idx <= r_idx + 1'b1;
                end
                S_RD: if (!r_found && r_next >= NW'(MAX_FLOWS)) begin
                    r_ovalid <= 1'b1;
                    r_st <= ipv6fc_pkg::ST_FULL;
                    r_fl <= '0; r_pi <= '0; r_dc <= '0;
                end
                S_WAIT: r_fcnt <= w_frd;
                S_WR: begin
                    if (!r_found) begin
                        r_next <= r_next + 1'b1;
                    end
                    r_ovalid <= 1'b1;
                    r_st <= ipv6fc_pkg::ST_OK;
                    r_fl <= 9'(r_hit + 1'b1);
                    r_pi <= 32'(w_fwd);
                    r_dc <= 32'(w_dwd);
                end
                default: ;
            endcase
        end
    end

    `AST_IMPL(a_hold, i_clk, i_rst_n, r_ovalid && !i_ready, ##1 r_ovalid)
    `AST_IMPL(a_noacc, i_clk, i_rst_n, r_state != S_IDLE, !o_ready)
    `AST_NEXT(a_alloc, i_clk, i_rst_n, r_state == S_WR && !r_found, r_next == $past(r_next) + 1'b1)
endmodule

FILE: verif/tb_ipv6_five_tuple_flow_classifier_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_ipv6_five_tuple_flow_classifier_top
// Self-checking bench for the IPv6 five-tuple flow classifier.
// Header summaries go in on s_axis, and each result beat on m_axis is checked
// against a local flow-table model. The run covers the reject paths, flow
// allocation, repeat hits, per-DSCP counts and a full table, with random
// gaps on the input side and random stalls on the output side.
// ---------------------------------------------------------------------------
module tb_ipv6_five_tuple_flow_classifier_top;

    localparam int  NUM_FLOWS   = 256;
    localparam int  RAND_ITEMS  = 1820;
    localparam int  DATA_IN_W   = 320;
    localparam longint LIMIT    = 64'd6_000_000;

    typedef struct {
        logic [63:0] sh, sl, dh, dl;
        logic [7:0]  nh;
        logic [15:0] plen, sp, dp;
        logic [5:0]  dscp;
    } t_hdr;

    typedef struct {
        ipv6fc_pkg::t_status status;
        logic [8:0]  flow;
        logic [31:0] pidx;
        logic [31:0] dcnt;
    } t_res;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // src_addr_hi, src_addr_lo, dst_addr_hi, dst_addr_lo, next_header,
    // payload_length, source_port, destination_port, dscp, zero fill
    logic [319:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // status, flow_number, packet_index, dscp_packet_count, zero fill
    logic [79:0]  m_axis_tdata;

    ipv6_five_tuple_flow_classifier_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // flow table mirror
    logic [295:0] flow_key   [NUM_FLOWS];
    bit           flow_used  [NUM_FLOWS];
    logic [31:0]  flow_pkts  [NUM_FLOWS];
    logic [31:0]  dscp_pkts  [NUM_FLOWS*64];
    int           flows_alloc;

    t_res   pending_res[$];
    t_hdr   known_flows[$];
    int     n_mismatch, n_results, n_sent, n_full, n_reject;
    longint cycles;
    bit     quiet;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [31:0] sat_add1(logic [31:0] v);
        return (v == '1) ? v : v + 32'd1;
    endfunction

    // fields from the lowest bit up, two zero bits on top
    function automatic logic [DATA_IN_W-1:0] pack_hdr(t_hdr h);
        return {2'b00, h.dscp, h.dp, h.sp, h.plen, h.nh, h.dl, h.dh, h.sl, h.sh};
    endfunction

    function automatic t_res classify(t_hdr h);
        t_res        r;
        logic [295:0] k;
        logic [5:0]  code;
        int          hit;
        code = h.dscp;
        r = '{ipv6fc_pkg::ST_OK, 9'd0, 32'd0, 32'd0};
        if (h.dh[63:56] == ipv6fc_pkg::MCAST_BYTE) begin
            r.status = ipv6fc_pkg::ST_MCAST;
            return r;
        end
        if (h.nh != ipv6fc_pkg::PROTO_TCP && h.nh != ipv6fc_pkg::PROTO_UDP) begin
            r.status = ipv6fc_pkg::ST_PROTO;
            return r;
        end
        if (h.plen < ipv6fc_pkg::MIN_PAYLOAD) begin
            r.status = ipv6fc_pkg::ST_SHORT;
            return r;
        end
        k = {h.sh, h.sl, h.dh, h.dl, h.nh, h.sp, h.dp};
        hit = -1;
        for (int i = 0; i < NUM_FLOWS; i++)
            if (hit < 0 && flow_used[i] && flow_key[i] == k) hit = i;
        if (hit >= 0) begin
            flow_pkts[hit] = sat_add1(flow_pkts[hit]);
        end else begin
            if (flows_alloc >= NUM_FLOWS) begin
                r.status = ipv6fc_pkg::ST_FULL;
                return r;
            end
            hit = flows_alloc;
            flows_alloc++;
            flow_used[hit] = 1'b1;
            flow_key[hit]  = k;
            flow_pkts[hit] = 32'd0;
        end
        dscp_pkts[hit*64 + code] = sat_add1(dscp_pkts[hit*64 + code]);
        r.flow = 9'(hit + 1);
        r.pidx = flow_pkts[hit];
        r.dcnt = dscp_pkts[hit*64 + code];
        return r;
    endfunction

    // one header beat; the expected result is queued on acceptance
    task automatic send_hdr(t_hdr h);
        t_res r;
        if (!quiet && $urandom_range(99) < 10) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pack_hdr(h);
        do @(posedge i_clk); while (!s_axis_tready);
        r = classify(h);
        pending_res.push_back(r);
        n_sent++;
        if (r.status == ipv6fc_pkg::ST_FULL) n_full++;
        else if (r.status != ipv6fc_pkg::ST_OK) n_reject++;
        if (r.status == ipv6fc_pkg::ST_OK && r.pidx == 0) known_flows.push_back(h);
    endtask

    function automatic t_hdr fresh_flow();
        t_hdr h;
        h.sh = {$urandom, $urandom};
        h.sl = {$urandom, $urandom};
        h.dh = {$urandom, $urandom};
        if (h.dh[63:56] == ipv6fc_pkg::MCAST_BYTE) h.dh[63:56] = 8'h20;
        h.dl   = {$urandom, $urandom};
        h.nh   = $urandom_range(1) ? ipv6fc_pkg::PROTO_TCP : ipv6fc_pkg::PROTO_UDP;
        h.plen = 16'($urandom_range(4, 65535));
        h.sp   = 16'($urandom);
        h.dp   = 16'($urandom);
        h.dscp = 6'($urandom);
        return h;
    endfunction

    // repeat of a known flow with new length and dscp
    function automatic t_hdr repeat_flow();
        t_hdr h;
        h = known_flows[$urandom_range(known_flows.size() - 1)];
        h.plen = 16'($urandom_range(4, 65535));
        h.dscp = $urandom_range(3) == 0 ? 6'($urandom) : 6'($urandom_range(3));
        return h;
    endfunction

    function automatic t_hdr broken_hdr();
        t_hdr h;
        h = (known_flows.size() > 0 && $urandom_range(1)) ? repeat_flow() : fresh_flow();
        case ($urandom_range(2))
            0: h.dh[63:56] = ipv6fc_pkg::MCAST_BYTE;
            1: begin
                h.nh = 8'($urandom);
                if (h.nh == ipv6fc_pkg::PROTO_TCP || h.nh == ipv6fc_pkg::PROTO_UDP)
                    h.nh = 8'd0;
            end
            default: h.plen = 16'($urandom_range(3));
        endcase
        return h;
    endfunction

    // result checker and output stalls
    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_results++;
            if (pending_res.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("ERROR: unexpected result beat %h", m_axis_tdata);
            end else begin
                e = pending_res.pop_front();
                if (m_axis_tdata[2:0] !== e.status || m_axis_tdata[11:3] !== e.flow ||
                    m_axis_tdata[43:12] !== e.pidx || m_axis_tdata[75:44] !== e.dcnt) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("ERROR: result %0d exp st=%0d fl=%0d pi=%0d dc=%0d got %h",
                                 n_results, e.status, e.flow, e.pidx, e.dcnt,
                                 m_axis_tdata[75:0]);
                end
            end
        end
        m_axis_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 10);
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic test_rejects();
        t_hdr h;
        h = fresh_flow(); h.dh[63:56] = ipv6fc_pkg::MCAST_BYTE; h.nh = 8'd3; h.plen = 16'd0;
        send_hdr(h);                          // multicast wins over the rest
        h = fresh_flow(); h.dh = {8'hff, 56'd0}; send_hdr(h);
        h = fresh_flow(); h.dh = '1; h.sh = '1; send_hdr(h);
        h = fresh_flow(); h.nh = 8'd0; h.plen = 16'd1; send_hdr(h);
        h = fresh_flow(); h.nh = 8'hff; send_hdr(h);
        h = fresh_flow(); h.nh = 8'd7; send_hdr(h);
        h = fresh_flow(); h.plen = 16'd0; send_hdr(h);
        h = fresh_flow(); h.plen = 16'd3; send_hdr(h);
    endtask

    task automatic test_alloc_and_hits();
        t_hdr h;
        h = '{64'd0, 64'd0, 64'd0, 64'd0, ipv6fc_pkg::PROTO_TCP, 16'd4, 16'd0, 16'd0, 6'd0};
        send_hdr(h);
        send_hdr(h);
        h.dscp = 6'd63; send_hdr(h);
        h.plen = 16'hffff; send_hdr(h);
        h.nh = ipv6fc_pkg::PROTO_UDP; send_hdr(h);   // same ports, other protocol
        h = '{'1, '1, 64'hfeff_ffff_ffff_ffff, '1, ipv6fc_pkg::PROTO_UDP, '1, '1, '1, 6'd63};
        send_hdr(h);
        send_hdr(h);
        h.dp = 16'hfffe; send_hdr(h);
        h = fresh_flow(); send_hdr(h); send_hdr(h);
    endtask

    task automatic test_random_traffic(int n);
        int k;
        for (k = 0; k < n; k++) begin
            quiet = (k >= n/3 && k < n/3 + 200);
            if ($urandom_range(99) < 12)
                send_hdr(broken_hdr());
            else if (known_flows.size() > 0 && $urandom_range(99) < 80)
                send_hdr(repeat_flow());
            else
                send_hdr(fresh_flow());
        end
        quiet = 1'b0;
    endtask

    // top the table up and push a few misses past the end
    task automatic test_table_full();
        while (flows_alloc < NUM_FLOWS) send_hdr(fresh_flow());
        repeat (4) send_hdr(fresh_flow());
        repeat (4) send_hdr(repeat_flow());
    endtask

    initial begin
        longint wait_cyc;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        quiet         = 1'b0;
        cycles        = 0;
        n_mismatch = 0; n_results = 0; n_sent = 0; n_full = 0; n_reject = 0;
        flows_alloc = 0;
        for (int i = 0; i < NUM_FLOWS; i++) begin
            flow_used[i] = 1'b0;
            flow_pkts[i] = '0;
            flow_key[i]  = '0;
        end
        for (int i = 0; i < NUM_FLOWS*64; i++) dscp_pkts[i] = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_rejects();
        test_alloc_and_hits();
        test_random_traffic(RAND_ITEMS);
        test_table_full();
        s_axis_tvalid <= 1'b0;

        // drain: worst case is a full-table walk per result
        wait_cyc = 0;
        while (pending_res.size() > 0 && wait_cyc < 200000) begin
            @(posedge i_clk);
            wait_cyc++;
        end
        repeat (600) @(posedge i_clk);

        $display("Sent %0d headers, %0d results checked, %0d flows allocated",
                 n_sent, n_results, flows_alloc);
        $display("Rejected %0d, table-full %0d, mismatches %0d",
                 n_reject, n_full, n_mismatch);
        if (n_mismatch == 0 && pending_res.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

FILE: sim.f
+incdir+sv
sv/ipv6fc_pkg.sv
sv/ipv6fc_ram.sv
sv/ipv6fc_front.sv
sv/ipv6fc_back.sv
sv/ipv6_five_tuple_flow_classifier_top.sv
verif/tb_ipv6_five_tuple_flow_classifier_top.sv
